// ----- hw/rtl/rcps_pkg.sv -----
// ----------------------------------------------------------------------------
// rcps_pkg
// Shared types, codes and constants of the river channel profile sampler.
// ----------------------------------------------------------------------------
package rcps_pkg;

  localparam int NodeDepthDefault = 1024;
  localparam int IdxW             = 10;

  localparam logic KindNode  = 1'b0;
  localparam logic KindQuery = 1'b1;

  typedef struct packed {
    logic               loaded;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic        [23:0] ch;
    logic        [23:0] va;
    logic signed [31:0] bed;
    logic signed [31:0] src;
  } node_t;

  typedef enum logic [4:0] {
    MulNone, MulDxDx, MulDyDy, MulFxDx, MulFyDy, MulDxT, MulDyT,
    MulXHH, MulXHL, MulXLL, MulYHH, MulYHL, MulYLL,
    MulChW, MulChT, MulVaW, MulVaT, MulBedW, MulBedT, MulSrcW, MulSrcT,
    MulUU, MulUUK, MulTgtW, MulTgtS
  } mul_e;

  typedef enum logic [5:0] {
    ActNone, ActDiff, ActLenSet, ActLenAdd, ActDotSet, ActDotAdd,
    ActTZero, ActTFull, ActTDivInit, ActDivStep, ActTFromQ,
    ActExSet, ActEySet, ActSqHH, ActSqAddHH, ActSqAddHL, ActSqAddLL,
    ActRootInit, ActRootStep, ActLFirst, ActStCh, ActStVa, ActStBed, ActStSrc,
    ActUZero, ActUFull, ActUDivInit, ActUFromQ, ActUUSet, ActSSet, ActStTgt,
    ActBestUpd, ActEmit
  } act_e;

  typedef struct packed {
    mul_e mul;
    act_e act;
    logic clr_en;
  } cmd_t;

  typedef struct packed {
    logic ok;
    logic len2_zero;
    logic dot_le0;
    logic dot_ge;
    logic e_big;
    logic beyond;
    logic u_zero;
    logic u_full;
    logic last;
    logic out_busy;
  } status_t;

endpackage

// ----- hw/rtl/rcps_if.sv -----
// ----------------------------------------------------------------------------
// rcps_if
// Channel interfaces: query/node input, sample output, extent write.
// ----------------------------------------------------------------------------
interface rcps_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic        [9:0]  node_index;
  logic        [9:0]  downstream_index;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic        [23:0] channel_half;
  logic        [23:0] valley_half;
  logic signed [31:0] bed_elevation;
  logic signed [31:0] source_elevation;
  logic               last;

  modport source (output valid, kind, node_index, downstream_index, pos_x, pos_y,
                  channel_half, valley_half, bed_elevation, source_elevation, last,
                  input ready);
  modport sink (input valid, kind, node_index, downstream_index, pos_x, pos_y,
                channel_half, valley_half, bed_elevation, source_elevation, last,
                output ready);
endinterface

interface rcps_out_if;
  logic               valid;
  logic               ready;
  logic               active;
  logic signed [31:0] target_elevation;
  logic        [23:0] center_distance;
  logic        [16:0] influence;
  logic        [23:0] out_channel_half;
  logic        [23:0] out_valley_half;

  modport source (output valid, active, target_elevation, center_distance, influence,
                  out_channel_half, out_valley_half, input ready);
  modport sink (input valid, active, target_elevation, center_distance, influence,
                out_channel_half, out_valley_half, output ready);
endinterface

interface rcps_cfg_if;
  logic        valid;
  logic        ready;
  logic [30:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

// ----- hw/rtl/rcps_node_mem.sv -----
// ----------------------------------------------------------------------------
// rcps_node_mem
// Node record table: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module rcps_node_mem #(
  parameter int NODE_DEPTH = rcps_pkg::NodeDepthDefault,
  localparam int AW = $clog2(NODE_DEPTH)
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  rcps_pkg::node_t wdata_i,
  input  logic            re_i,
  input  logic [AW-1:0]   raddr_a_i,
  input  logic [AW-1:0]   raddr_b_i,
  output rcps_pkg::node_t rdata_a_o,
  output rcps_pkg::node_t rdata_b_o
);

  rcps_pkg::node_t mem [NODE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule

// ----- hw/rtl/rcps_ctrl.sv -----
// ----------------------------------------------------------------------------
// rcps_ctrl
// Sequencer: clearing pass, item accept, per-segment step schedule.
// ----------------------------------------------------------------------------
module rcps_ctrl #(
  parameter int NODE_DEPTH = rcps_pkg::NodeDepthDefault,
  localparam int AW = $clog2(NODE_DEPTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_kind_i,
  output logic              in_ready_o,
  input  rcps_pkg::status_t status_i,
  output rcps_pkg::cmd_t    cmd_o,
  output logic [AW-1:0]     clr_addr_o
);

  localparam logic [5:0] S_CLR = 6'd0, S_IDLE = 6'd1, S_RD = 6'd2;
  localparam logic [5:0] S_M0 = 6'd3, S_M1 = 6'd4, S_M2 = 6'd5, S_M3 = 6'd6, S_M4 = 6'd7;
  localparam logic [5:0] S_TCHK = 6'd8, S_TDIV = 6'd9, S_TQ = 6'd10;
  localparam logic [5:0] S_E0 = 6'd11, S_E1 = 6'd12, S_E2 = 6'd13, S_ECHK = 6'd14;
  localparam logic [5:0] S_Q1 = 6'd15, S_Q2 = 6'd16, S_Q3 = 6'd17, S_Q4 = 6'd18;
  localparam logic [5:0] S_Q5 = 6'd19, S_Q6 = 6'd20, S_RINIT = 6'd21, S_ROOT = 6'd22;
  localparam logic [5:0] S_L0 = 6'd23, S_L1 = 6'd24, S_L2 = 6'd25, S_L3 = 6'd26;
  localparam logic [5:0] S_L4 = 6'd27, S_L5 = 6'd28, S_L6 = 6'd29, S_L7 = 6'd30;
  localparam logic [5:0] S_L8 = 6'd31, S_UCHK = 6'd32, S_UDIV = 6'd33, S_UQ = 6'd34;
  localparam logic [5:0] S_S0 = 6'd35, S_S1 = 6'd36, S_S2 = 6'd37, S_S3 = 6'd38;
  localparam logic [5:0] S_G0 = 6'd39, S_G1 = 6'd40, S_G2 = 6'd41;
  localparam logic [5:0] S_UPD = 6'd42, S_FIN = 6'd43;

  localparam logic [4:0] DivLast  = 5'd15;
  localparam logic [4:0] RootLast = 5'd24;
  localparam logic [AW-1:0] ClrLast = AW'(NODE_DEPTH - 1);

  logic [5:0]    st_q, st_d;
  logic [4:0]    cnt_q, cnt_d;
  logic [AW-1:0] clr_q, clr_d;

  assign clr_addr_o = clr_q;

  always_comb begin
    st_d       = st_q;
    cnt_d      = cnt_q;
    clr_d      = clr_q;
    in_ready_o = 1'b0;
    cmd_o      = '{mul: rcps_pkg::MulNone, act: rcps_pkg::ActNone, clr_en: 1'b0};
    unique case (st_q)
      S_CLR: begin
        cmd_o.clr_en = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == ClrLast) st_d = S_IDLE;
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i && in_kind_i == rcps_pkg::KindQuery) st_d = S_RD;
      end
      S_RD: begin
        if (status_i.ok) begin
          cmd_o.act = rcps_pkg::ActDiff;
          st_d = S_M0;
        end else begin
          st_d = S_FIN;
        end
      end
      S_M0: begin cmd_o.mul = rcps_pkg::MulDxDx; st_d = S_M1; end
      S_M1: begin
        cmd_o.mul = rcps_pkg::MulDyDy; cmd_o.act = rcps_pkg::ActLenSet; st_d = S_M2;
      end
      S_M2: begin
        cmd_o.mul = rcps_pkg::MulFxDx; cmd_o.act = rcps_pkg::ActLenAdd; st_d = S_M3;
      end
      S_M3: begin
        cmd_o.mul = rcps_pkg::MulFyDy; cmd_o.act = rcps_pkg::ActDotSet; st_d = S_M4;
      end
      S_M4: begin cmd_o.act = rcps_pkg::ActDotAdd; st_d = S_TCHK; end
      S_TCHK: begin
        cnt_d = '0;
        if (status_i.len2_zero) begin
          st_d = S_FIN;
        end else if (status_i.dot_le0) begin
          cmd_o.act = rcps_pkg::ActTZero; st_d = S_E0;
        end else if (status_i.dot_ge) begin
          cmd_o.act = rcps_pkg::ActTFull; st_d = S_E0;
        end else begin
          cmd_o.act = rcps_pkg::ActTDivInit; st_d = S_TDIV;
        end
      end
      S_TDIV: begin
        cmd_o.act = rcps_pkg::ActDivStep;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DivLast) st_d = S_TQ;
      end
      S_TQ: begin cmd_o.act = rcps_pkg::ActTFromQ; st_d = S_E0; end
      S_E0: begin cmd_o.mul = rcps_pkg::MulDxT; st_d = S_E1; end
      S_E1: begin
        cmd_o.mul = rcps_pkg::MulDyT; cmd_o.act = rcps_pkg::ActExSet; st_d = S_E2;
      end
      S_E2: begin cmd_o.act = rcps_pkg::ActEySet; st_d = S_ECHK; end
      S_ECHK: begin
        if (status_i.e_big) begin
          st_d = S_FIN;
        end else begin
          cmd_o.mul = rcps_pkg::MulXHH; st_d = S_Q1;
        end
      end
      S_Q1: begin
        cmd_o.mul = rcps_pkg::MulXHL; cmd_o.act = rcps_pkg::ActSqHH; st_d = S_Q2;
      end
      S_Q2: begin
        cmd_o.mul = rcps_pkg::MulXLL; cmd_o.act = rcps_pkg::ActSqAddHL; st_d = S_Q3;
      end
      S_Q3: begin
        cmd_o.mul = rcps_pkg::MulYHH; cmd_o.act = rcps_pkg::ActSqAddLL; st_d = S_Q4;
      end
      S_Q4: begin
        cmd_o.mul = rcps_pkg::MulYHL; cmd_o.act = rcps_pkg::ActSqAddHH; st_d = S_Q5;
      end
      S_Q5: begin
        cmd_o.mul = rcps_pkg::MulYLL; cmd_o.act = rcps_pkg::ActSqAddHL; st_d = S_Q6;
      end
      S_Q6: begin cmd_o.act = rcps_pkg::ActSqAddLL; st_d = S_RINIT; end
      S_RINIT: begin
        cmd_o.act = rcps_pkg::ActRootInit; cnt_d = '0; st_d = S_ROOT;
      end
      S_ROOT: begin
        cmd_o.act = rcps_pkg::ActRootStep;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == RootLast) st_d = S_L0;
      end
      S_L0: begin cmd_o.mul = rcps_pkg::MulChW; st_d = S_L1; end
      S_L1: begin
        cmd_o.mul = rcps_pkg::MulChT; cmd_o.act = rcps_pkg::ActLFirst; st_d = S_L2;
      end
      S_L2: begin
        cmd_o.mul = rcps_pkg::MulVaW; cmd_o.act = rcps_pkg::ActStCh; st_d = S_L3;
      end
      S_L3: begin
        cmd_o.mul = rcps_pkg::MulVaT; cmd_o.act = rcps_pkg::ActLFirst; st_d = S_L4;
      end
      S_L4: begin
        cmd_o.mul = rcps_pkg::MulBedW; cmd_o.act = rcps_pkg::ActStVa; st_d = S_L5;
      end
      S_L5: begin
        if (status_i.beyond) begin
          st_d = S_FIN;
        end else begin
          cmd_o.mul = rcps_pkg::MulBedT; cmd_o.act = rcps_pkg::ActLFirst; st_d = S_L6;
        end
      end
      S_L6: begin
        cmd_o.mul = rcps_pkg::MulSrcW; cmd_o.act = rcps_pkg::ActStBed; st_d = S_L7;
      end
      S_L7: begin
        cmd_o.mul = rcps_pkg::MulSrcT; cmd_o.act = rcps_pkg::ActLFirst; st_d = S_L8;
      end
      S_L8: begin cmd_o.act = rcps_pkg::ActStSrc; st_d = S_UCHK; end
      S_UCHK: begin
        cnt_d = '0;
        if (status_i.u_zero) begin
          cmd_o.act = rcps_pkg::ActUZero; st_d = S_S0;
        end else if (status_i.u_full) begin
          cmd_o.act = rcps_pkg::ActUFull; st_d = S_S0;
        end else begin
          cmd_o.act = rcps_pkg::ActUDivInit; st_d = S_UDIV;
        end
      end
      S_UDIV: begin
        cmd_o.act = rcps_pkg::ActDivStep;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DivLast) st_d = S_UQ;
      end
      S_UQ: begin cmd_o.act = rcps_pkg::ActUFromQ; st_d = S_S0; end
      S_S0: begin cmd_o.mul = rcps_pkg::MulUU; st_d = S_S1; end
      S_S1: begin cmd_o.act = rcps_pkg::ActUUSet; st_d = S_S2; end
      S_S2: begin cmd_o.mul = rcps_pkg::MulUUK; st_d = S_S3; end
      S_S3: begin cmd_o.act = rcps_pkg::ActSSet; st_d = S_G0; end
      S_G0: begin cmd_o.mul = rcps_pkg::MulTgtW; st_d = S_G1; end
      S_G1: begin
        cmd_o.mul = rcps_pkg::MulTgtS; cmd_o.act = rcps_pkg::ActLFirst; st_d = S_G2;
      end
      S_G2: begin cmd_o.act = rcps_pkg::ActStTgt; st_d = S_UPD; end
      S_UPD: begin cmd_o.act = rcps_pkg::ActBestUpd; st_d = S_FIN; end
      S_FIN: begin
        if (!status_i.last) begin
          st_d = S_IDLE;
        end else if (!status_i.out_busy) begin
          cmd_o.act = rcps_pkg::ActEmit;
          st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= S_CLR;
      cnt_q <= '0;
      clr_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      clr_q <= clr_d;
    end
  end

`ifndef SYNTH
  a_query_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_kind_i == rcps_pkg::KindQuery |=> st_q == S_RD)
    else $error("query beat not followed by table read");
  a_tdiv_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_TDIV && cnt_q == DivLast |=> st_q == S_TQ)
    else $error("divider ran wrong step count");
  a_clr_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == S_CLR |-> !in_ready_o && cmd_o.clr_en)
    else $error("input taken during clearing pass");
`endif

endmodule

// ----- hw/rtl/rcps_datapath.sv -----
// ----------------------------------------------------------------------------
// rcps_datapath
// Shared multiplier, divider and square-root units, kept sample and output.
// ----------------------------------------------------------------------------
module rcps_datapath #(
  parameter int NODE_DEPTH = rcps_pkg::NodeDepthDefault,
  localparam int AW = $clog2(NODE_DEPTH)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rcps_pkg::cmd_t     cmd_i,
  input  logic [AW-1:0]      clr_addr_i,
  output rcps_pkg::status_t  status_o,
  input  logic               in_fire_i,
  input  logic               in_kind_i,
  input  logic [9:0]         in_node_index_i,
  input  logic [9:0]         in_downstream_index_i,
  input  logic signed [31:0] in_pos_x_i,
  input  logic signed [31:0] in_pos_y_i,
  input  logic [23:0]        in_channel_half_i,
  input  logic [23:0]        in_valley_half_i,
  input  logic signed [31:0] in_bed_elevation_i,
  input  logic signed [31:0] in_source_elevation_i,
  input  logic               in_last_i,
  input  logic               cfg_valid_i,
  input  logic [30:0]        cfg_data_i,
  output logic               mem_we_o,
  output logic [AW-1:0]      mem_waddr_o,
  output rcps_pkg::node_t    mem_wdata_o,
  output logic               mem_re_o,
  output logic [AW-1:0]      mem_raddr_a_o,
  output logic [AW-1:0]      mem_raddr_b_o,
  input  rcps_pkg::node_t    mem_rdata_a_i,
  input  rcps_pkg::node_t    mem_rdata_b_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output logic               out_active_o,
  output logic signed [31:0] out_target_elevation_o,
  output logic [23:0]        out_center_distance_o,
  output logic [16:0]        out_influence_o,
  output logic [23:0]        out_channel_half_o,
  output logic [23:0]        out_valley_half_o
);

  localparam int ExtW = AW + rcps_pkg::IdxW;

  logic [30:0] ext_q;
  logic [ExtW-1:0] up_ext, dn_ext;
  logic up_ok, dn_ok, px_ok, py_ok;
  logic [32:0] pxm, pym;
  logic is_node, is_query;

  logic signed [31:0] px_q, py_q;
  logic last_q, idx_ok_q, ext_ok_q;

  logic signed [32:0] dx_q, dy_q, fx_q, fy_q;
  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] p_q;
  logic [66:0] len2_q;
  logic signed [67:0] dot_q;
  logic [67:0] rem_q, r2, r2s;
  logic [66:0] div_q;
  logic [15:0] quo_q;
  logic div_ge;
  logic [16:0] t_q, w_t;
  logic signed [50:0] ex_q, ey_q;
  logic [50:0] mx, my;
  logic [81:0] sq_q;
  logic [49:0] rad_q;
  logic [27:0] rrem_q, rr, trial;
  logic [24:0] root_q;
  logic signed [49:0] lacc_q, lsum;
  logic [23:0] ch_q, va_q, bw;
  logic signed [31:0] bed_q, src_q, tgt_q;
  logic [24:0] dc;
  logic [16:0] u_q, s_q, w_s;
  logic [17:0] kk;
  logic [31:0] uu_q;

  logic bv_q;
  logic signed [31:0] bt_q;
  logic [23:0] bd_q, bc_q, bva_q;
  logic [16:0] bi_q;

  assign is_node  = in_kind_i == rcps_pkg::KindNode;
  assign is_query = in_kind_i == rcps_pkg::KindQuery;
  assign up_ext   = ExtW'(in_node_index_i);
  assign dn_ext   = ExtW'(in_downstream_index_i);
  assign up_ok    = 32'(in_node_index_i) < NODE_DEPTH;
  assign dn_ok    = 32'(in_downstream_index_i) < NODE_DEPTH;
  assign pxm      = in_pos_x_i[31] ? 33'd0 - 33'(in_pos_x_i) : 33'(in_pos_x_i);
  assign pym      = in_pos_y_i[31] ? 33'd0 - 33'(in_pos_y_i) : 33'(in_pos_y_i);
  assign px_ok    = pxm <= 33'(ext_q);
  assign py_ok    = pym <= 33'(ext_q);

  // table access
  always_comb begin
    mem_we_o    = cmd_i.clr_en || (in_fire_i && is_node && up_ok);
    mem_waddr_o = cmd_i.clr_en ? clr_addr_i : up_ext[AW-1:0];
    if (cmd_i.clr_en) begin
      mem_wdata_o = '0;
    end else begin
      mem_wdata_o = '{loaded: 1'b1, x: in_pos_x_i, y: in_pos_y_i, ch: in_channel_half_i,
                      va: in_valley_half_i, bed: in_bed_elevation_i,
                      src: in_source_elevation_i};
    end
  end
  assign mem_re_o      = in_fire_i && is_query;
  assign mem_raddr_a_o = up_ext[AW-1:0];
  assign mem_raddr_b_o = dn_ext[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ext_q <= '1;
    end else if (cfg_valid_i) begin
      ext_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire_i && is_query) begin
      px_q     <= in_pos_x_i;
      py_q     <= in_pos_y_i;
      last_q   <= in_last_i;
      idx_ok_q <= up_ok && dn_ok;
      ext_ok_q <= px_ok && py_ok;
    end
  end

  // operand select for the shared multiplier
  assign w_t = 17'd65536 - t_q;
  assign w_s = 17'd65536 - s_q;
  assign kk  = 18'd196608 - {u_q, 1'b0};
  assign mx  = ex_q[50] ? 51'(-ex_q) : 51'(ex_q);
  assign my  = ey_q[50] ? 51'(-ey_q) : 51'(ey_q);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.mul)
      rcps_pkg::MulDxDx: begin mul_a = 34'(dx_q); mul_b = 34'(dx_q); end
      rcps_pkg::MulDyDy: begin mul_a = 34'(dy_q); mul_b = 34'(dy_q); end
      rcps_pkg::MulFxDx: begin mul_a = 34'(fx_q); mul_b = 34'(dx_q); end
      rcps_pkg::MulFyDy: begin mul_a = 34'(fy_q); mul_b = 34'(dy_q); end
      rcps_pkg::MulDxT:  begin mul_a = 34'(dx_q); mul_b = 34'(t_q); end
      rcps_pkg::MulDyT:  begin mul_a = 34'(dy_q); mul_b = 34'(t_q); end
      rcps_pkg::MulXHH:  begin mul_a = 34'(mx[39:20]); mul_b = 34'(mx[39:20]); end
      rcps_pkg::MulXHL:  begin mul_a = 34'(mx[39:20]); mul_b = 34'(mx[19:0]); end
      rcps_pkg::MulXLL:  begin mul_a = 34'(mx[19:0]); mul_b = 34'(mx[19:0]); end
      rcps_pkg::MulYHH:  begin mul_a = 34'(my[39:20]); mul_b = 34'(my[39:20]); end
      rcps_pkg::MulYHL:  begin mul_a = 34'(my[39:20]); mul_b = 34'(my[19:0]); end
      rcps_pkg::MulYLL:  begin mul_a = 34'(my[19:0]); mul_b = 34'(my[19:0]); end
      rcps_pkg::MulChW:  begin mul_a = 34'(mem_rdata_a_i.ch); mul_b = 34'(w_t); end
      rcps_pkg::MulChT:  begin mul_a = 34'(mem_rdata_b_i.ch); mul_b = 34'(t_q); end
      rcps_pkg::MulVaW:  begin mul_a = 34'(mem_rdata_a_i.va); mul_b = 34'(w_t); end
      rcps_pkg::MulVaT:  begin mul_a = 34'(mem_rdata_b_i.va); mul_b = 34'(t_q); end
      rcps_pkg::MulBedW: begin mul_a = 34'(mem_rdata_a_i.bed); mul_b = 34'(w_t); end
      rcps_pkg::MulBedT: begin mul_a = 34'(mem_rdata_b_i.bed); mul_b = 34'(t_q); end
      rcps_pkg::MulSrcW: begin mul_a = 34'(mem_rdata_a_i.src); mul_b = 34'(w_t); end
      rcps_pkg::MulSrcT: begin mul_a = 34'(mem_rdata_b_i.src); mul_b = 34'(t_q); end
      rcps_pkg::MulUU:   begin mul_a = 34'(u_q); mul_b = 34'(u_q); end
      rcps_pkg::MulUUK:  begin mul_a = 34'(uu_q); mul_b = 34'(kk); end
      rcps_pkg::MulTgtW: begin mul_a = 34'(bed_q); mul_b = 34'(w_s); end
      rcps_pkg::MulTgtS: begin mul_a = 34'(src_q); mul_b = 34'(s_q); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign r2     = {rem_q[66:0], 1'b0};
  assign div_ge = r2 >= {1'b0, div_q};
  assign r2s    = r2 - {1'b0, div_q};
  assign rr     = {rrem_q[25:0], rad_q[49:48]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign lsum   = lacc_q + $signed(p_q[49:0]);
  assign dc     = root_q - {1'b0, ch_q};
  assign bw     = (va_q > ch_q) ? va_q - ch_q : 24'd1;

  always_ff @(posedge clk_i) begin
    p_q <= mul_a * mul_b;
    case (cmd_i.act)
      rcps_pkg::ActDiff: begin
        dx_q <= 33'(mem_rdata_b_i.x) - 33'(mem_rdata_a_i.x);
        dy_q <= 33'(mem_rdata_b_i.y) - 33'(mem_rdata_a_i.y);
        fx_q <= 33'(px_q) - 33'(mem_rdata_a_i.x);
        fy_q <= 33'(py_q) - 33'(mem_rdata_a_i.y);
      end
      rcps_pkg::ActLenSet:   len2_q <= p_q[66:0];
      rcps_pkg::ActLenAdd:   len2_q <= len2_q + p_q[66:0];
      rcps_pkg::ActDotSet:   dot_q <= p_q;
      rcps_pkg::ActDotAdd:   dot_q <= dot_q + p_q;
      rcps_pkg::ActTZero:    t_q <= '0;
      rcps_pkg::ActTFull:    t_q <= 17'd65536;
      rcps_pkg::ActTDivInit: begin
        rem_q <= {1'b0, dot_q[66:0]};
        div_q <= len2_q;
      end
      rcps_pkg::ActDivStep: begin
        rem_q <= div_ge ? r2s : r2;
        quo_q <= {quo_q[14:0], div_ge};
      end
      rcps_pkg::ActTFromQ:   t_q <= {1'b0, quo_q};
      rcps_pkg::ActExSet:    ex_q <= (51'(fx_q) <<< 16) - 51'(p_q);
      rcps_pkg::ActEySet:    ey_q <= (51'(fy_q) <<< 16) - 51'(p_q);
      rcps_pkg::ActSqHH:     sq_q <= 82'(p_q[39:0]) << 40;
      rcps_pkg::ActSqAddHH:  sq_q <= sq_q + (82'(p_q[39:0]) << 40);
      rcps_pkg::ActSqAddHL:  sq_q <= sq_q + (82'(p_q[39:0]) << 21);
      rcps_pkg::ActSqAddLL:  sq_q <= sq_q + 82'(p_q[39:0]);
      rcps_pkg::ActRootInit: begin
        rad_q  <= sq_q[81:32];
        rrem_q <= '0;
        root_q <= '0;
      end
      rcps_pkg::ActRootStep: begin
        rad_q <= {rad_q[47:0], 2'b00};
        if (rr >= trial) begin
          rrem_q <= rr - trial;
          root_q <= {root_q[23:0], 1'b1};
        end else begin
          rrem_q <= rr;
          root_q <= {root_q[23:0], 1'b0};
        end
      end
      rcps_pkg::ActLFirst:   lacc_q <= $signed(p_q[49:0]);
      rcps_pkg::ActStCh:     ch_q <= lsum[39:16];
      rcps_pkg::ActStVa:     va_q <= lsum[39:16];
      rcps_pkg::ActStBed:    bed_q <= lsum[47:16];
      rcps_pkg::ActStSrc:    src_q <= lsum[47:16];
      rcps_pkg::ActUZero:    u_q <= '0;
      rcps_pkg::ActUFull:    u_q <= 17'd65536;
      rcps_pkg::ActUDivInit: begin
        rem_q <= 68'(dc);
        div_q <= 67'(bw);
      end
      rcps_pkg::ActUFromQ:   u_q <= {1'b0, quo_q};
      rcps_pkg::ActUUSet:    uu_q <= p_q[31:0];
      rcps_pkg::ActSSet:     s_q <= u_q[16] ? 17'd65536 : p_q[48:32];
      rcps_pkg::ActStTgt:    tgt_q <= lsum[47:16];
      default: ;
    endcase
  end

  // kept sample and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q        <= 1'b0;
      bt_q        <= '0;
      bd_q        <= '0;
      bi_q        <= '0;
      bc_q        <= '0;
      bva_q       <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (cmd_i.act == rcps_pkg::ActBestUpd && (!bv_q || tgt_q < bt_q)) begin
        bv_q  <= 1'b1;
        bt_q  <= tgt_q;
        bd_q  <= root_q[23:0];
        bi_q  <= w_s;
        bc_q  <= ch_q;
        bva_q <= va_q;
      end
      if (cmd_i.act == rcps_pkg::ActEmit) begin
        out_valid_o <= 1'b1;
        bv_q  <= 1'b0;
        bt_q  <= '0;
        bd_q  <= '0;
        bi_q  <= '0;
        bc_q  <= '0;
        bva_q <= '0;
      end else if (out_valid_o && out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.act == rcps_pkg::ActEmit) begin
      out_active_o           <= bv_q;
      out_target_elevation_o <= bt_q;
      out_center_distance_o  <= bd_q;
      out_influence_o        <= bi_q;
      out_channel_half_o     <= bc_q;
      out_valley_half_o      <= bva_q;
    end
  end

  always_comb begin
    status_o.ok        = idx_ok_q && ext_ok_q && mem_rdata_a_i.loaded && mem_rdata_b_i.loaded;
    status_o.len2_zero = len2_q == '0;
    status_o.dot_le0   = dot_q[67] || dot_q == '0;
    status_o.dot_ge    = !dot_q[67] && dot_q[66:0] >= len2_q;
    status_o.e_big     = (|mx[50:40]) || (|my[50:40]);
    status_o.beyond    = root_q > {1'b0, va_q};
    status_o.u_zero    = root_q <= {1'b0, ch_q};
    status_o.u_full    = dc >= {1'b0, bw};
    status_o.last      = last_q;
    status_o.out_busy  = out_valid_o && !out_ready_i;
  end

`ifndef SYNTH
  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.act == rcps_pkg::ActEmit |=> out_valid_o && !bv_q)
    else $error("emit did not load output or clear kept sample");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.act == rcps_pkg::ActEmit |-> !(out_valid_o && !out_ready_i))
    else $error("result overwritten while waiting");
  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.act == rcps_pkg::ActDivStep |-> rem_q[66:0] < {1'b0, div_q[65:0]} || div_q[66])
    else $error("divider remainder out of range");
`endif

endmodule

// ----- hw/rtl/river_channel_profile_sample_top.sv -----
// ----------------------------------------------------------------------------
// river_channel_profile_sample_top
// River channel profile sampler: node table, segment projection, bank blend.
//
//   channel  dir  beat carries
//   in_i     in   node record write or candidate segment query
//   out_o    out  kept sample, one beat per query run end
//   cfg_i    in   query half extent
//
// in_i stays ready after a node write. After a query beat the next beat is
// taken once every step has run: two 16-step divisions and a 25-step root
// beside the passes of one shared multiplier; a clamped t or bank position
// skips its division, and an inactive candidate leaves earlier.
// After reset a clearing pass zeroes all NODE_DEPTH entries before in_i is ready.
// A run-ending beat whose result finds out_o occupied holds in_i low until
// that result leaves.
// ----------------------------------------------------------------------------
module river_channel_profile_sample_top #(
  parameter int NODE_DEPTH = rcps_pkg::NodeDepthDefault
) (
  input logic       clk_i,
  input logic       rst_ni,
  rcps_in_if.sink   in_i,
  rcps_out_if.source out_o,
  rcps_cfg_if.sink  cfg_i
);

  localparam int AW = $clog2(NODE_DEPTH);

  rcps_pkg::cmd_t    cmd;
  rcps_pkg::status_t status;
  rcps_pkg::node_t   wdata, rdata_a, rdata_b;
  logic [AW-1:0] clr_addr, waddr, raddr_a, raddr_b;
  logic we, re, in_fire;

  assign in_fire     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  rcps_ctrl #(.NODE_DEPTH(NODE_DEPTH)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (in_i.valid),
    .in_kind_i  (in_i.kind),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd),
    .clr_addr_o (clr_addr)
  );

  rcps_datapath #(.NODE_DEPTH(NODE_DEPTH)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i                  (cmd),
    .clr_addr_i             (clr_addr),
    .status_o               (status),
    .in_fire_i              (in_fire),
    .in_kind_i              (in_i.kind),
    .in_node_index_i        (in_i.node_index),
    .in_downstream_index_i  (in_i.downstream_index),
    .in_pos_x_i             (in_i.pos_x),
    .in_pos_y_i             (in_i.pos_y),
    .in_channel_half_i      (in_i.channel_half),
    .in_valley_half_i       (in_i.valley_half),
    .in_bed_elevation_i     (in_i.bed_elevation),
    .in_source_elevation_i  (in_i.source_elevation),
    .in_last_i              (in_i.last),
    .cfg_valid_i            (cfg_i.valid),
    .cfg_data_i             (cfg_i.data),
    .mem_we_o               (we),
    .mem_waddr_o            (waddr),
    .mem_wdata_o            (wdata),
    .mem_re_o               (re),
    .mem_raddr_a_o          (raddr_a),
    .mem_raddr_b_o          (raddr_b),
    .mem_rdata_a_i          (rdata_a),
    .mem_rdata_b_i          (rdata_b),
    .out_ready_i            (out_o.ready),
    .out_valid_o            (out_o.valid),
    .out_active_o           (out_o.active),
    .out_target_elevation_o (out_o.target_elevation),
    .out_center_distance_o  (out_o.center_distance),
    .out_influence_o        (out_o.influence),
    .out_channel_half_o     (out_o.out_channel_half),
    .out_valley_half_o      (out_o.out_valley_half)
  );

  rcps_node_mem #(.NODE_DEPTH(NODE_DEPTH)) u_mem (
    .clk_i,
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .re_i      (re),
    .raddr_a_i (raddr_a),
    .raddr_b_i (raddr_b),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

endmodule

// ----- sim/river_channel_profile_sample_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// river_channel_profile_sample_top_test
// Self-checking bench for the river channel profile sampler. A queue-fed
// driver offers node writes and candidate runs with random gaps. A monitor
// stalls the output at random, once for a long stretch. Every accepted beat
// goes through a bit-exact profile predictor. Each output beat is compared
// field by field with the oldest predicted sample. The extent register is
// rewritten between phases, once the block has drained.
// ----------------------------------------------------------------------------
module river_channel_profile_sample_top_test;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic               kind;
    logic [9:0]         up_idx;
    logic [9:0]         dn_idx;
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic [23:0]        ch;
    logic [23:0]        va;
    logic signed [31:0] bed;
    logic signed [31:0] src;
    logic               last;
  } beat_t;

  typedef struct {
    logic        active;
    logic [31:0] target;
    logic [23:0] span;
    logic [16:0] infl;
    logic [23:0] ch;
    logic [23:0] va;
  } sample_t;

  localparam int  PoolSize   = 32;
  localparam int  DrainWait  = 200;
  localparam longint CycleLimit = 3000000;

  logic clk = 1'b0;
  logic rst_n;

  rcps_in_if  in_bus ();
  rcps_out_if out_bus ();
  rcps_cfg_if cfg_bus ();

  river_channel_profile_sample_top dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_bus),
    .out_o (out_bus),
    .cfg_i (cfg_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  beat_t   pending_beats[$];
  sample_t expected_samples[$];
  int      errors      = 0;
  int      beats_in    = 0;
  int      samples_out = 0;
  int      active_seen = 0;
  longint  cycles      = 0;
  bit      calm        = 0;
  int      hold_left   = 0;
  bit      hold_done   = 0;

  // profile predictor state
  longint  extent;
  longint  node_x[PoolSize * 32];
  longint  node_y[PoolSize * 32];
  longint  node_ch[PoolSize * 32];
  longint  node_va[PoolSize * 32];
  longint  node_bed[PoolSize * 32];
  longint  node_src[PoolSize * 32];
  bit      node_loaded[PoolSize * 32];
  bit      best_valid;
  longint  best_target, best_span, best_infl, best_ch, best_va;

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint blend_signed(longint a, longint b, longint t);
    longint v;
    v = a * (65536 - t) + b * t;
    return v >>> 16;
  endfunction

  function automatic longint blend_width(longint a, longint b, longint t);
    return (a * (65536 - t) + b * t) >>> 16;
  endfunction

  function automatic void clear_best();
    best_valid = 0;
    best_target = 0;
    best_span = 0;
    best_infl = 0;
    best_ch = 0;
    best_va = 0;
  endfunction

  function automatic void sample_segment(int up, int dn, longint px, longint py);
    longint dx, dy, fx, fy, t, ch, va, bed, src, bw, u, s, tgt;
    wide_t  len2, dot, ex, ey, sq, lim;
    longint unsigned span;
    if (!node_loaded[up] || !node_loaded[dn]) return;
    if (mag(px) > extent || mag(py) > extent) return;
    dx = node_x[dn] - node_x[up];
    dy = node_y[dn] - node_y[up];
    fx = px - node_x[up];
    fy = py - node_y[up];
    len2 = wide_t'(dx) * wide_t'(dx) + wide_t'(dy) * wide_t'(dy);
    if (len2 == 0) return;
    dot = wide_t'(fx) * wide_t'(dx) + wide_t'(fy) * wide_t'(dy);
    if (dot <= 0) t = 0;
    else if (dot >= len2) t = 65536;
    else t = longint'((dot <<< 16) / len2);
    ex = wide_t'(fx) * 65536 - wide_t'(dx) * wide_t'(t);
    ey = wide_t'(fy) * 65536 - wide_t'(dy) * wide_t'(t);
    lim = wide_t'(1) <<< 40;
    if ((ex < 0 ? -ex : ex) >= lim || (ey < 0 ? -ey : ey) >= lim) return;
    sq = ex * ex + ey * ey;
    span = root_floor(64'(sq >> 32));
    ch = blend_width(node_ch[up], node_ch[dn], t);
    va = blend_width(node_va[up], node_va[dn], t);
    if (longint'(span) > va) return;
    bed = blend_signed(node_bed[up], node_bed[dn], t);
    src = blend_signed(node_src[up], node_src[dn], t);
    bw = (va > ch) ? va - ch : 1;
    if (longint'(span) <= ch) u = 0;
    else if (longint'(span) - ch >= bw) u = 65536;
    else u = ((longint'(span) - ch) << 16) / bw;
    s = longint'((64'(u) * 64'(u) * 64'(196608 - 2 * u)) >> 32);
    tgt = blend_signed(bed, src, s);
    if (!best_valid || tgt < best_target) begin
      best_valid = 1;
      best_target = tgt;
      best_span = longint'(span);
      best_infl = 65536 - s;
      best_ch = ch;
      best_va = va;
    end
  endfunction

  function automatic void predict_beat(beat_t b);
    sample_t r;
    if (b.kind == rcps_pkg::KindNode) begin
      node_x[b.up_idx] = b.px;
      node_y[b.up_idx] = b.py;
      node_ch[b.up_idx] = b.ch;
      node_va[b.up_idx] = b.va;
      node_bed[b.up_idx] = b.bed;
      node_src[b.up_idx] = b.src;
      node_loaded[b.up_idx] = 1;
      return;
    end
    sample_segment(b.up_idx, b.dn_idx, b.px, b.py);
    if (!b.last) return;
    r.active = best_valid;
    r.target = best_target[31:0];
    r.span = best_span[23:0];
    r.infl = best_infl[16:0];
    r.ch = best_ch[23:0];
    r.va = best_va[23:0];
    expected_samples = {expected_samples, r};
    clear_best();
  endfunction

  function automatic int gap_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // stimulus builders
  function automatic void push_node(int idx, longint x, longint y, longint ch, longint va,
                                    longint bed, longint src);
    beat_t b;
    b.kind = rcps_pkg::KindNode;
    b.up_idx = 10'(idx);
    b.dn_idx = 10'($urandom_range(0, 1023));
    b.px = 32'(x);
    b.py = 32'(y);
    b.ch = 24'(ch);
    b.va = 24'(va);
    b.bed = 32'(bed);
    b.src = 32'(src);
    b.last = 1'($urandom_range(0, 1));
    pending_beats = {pending_beats, b};
  endfunction

  function automatic void push_query(int up, int dn, longint x, longint y, bit last);
    beat_t b;
    b.kind = rcps_pkg::KindQuery;
    b.up_idx = 10'(up);
    b.dn_idx = 10'(dn);
    b.px = 32'(x);
    b.py = 32'(y);
    b.ch = 24'($urandom);
    b.va = 24'($urandom);
    b.bed = $urandom;
    b.src = $urandom;
    b.last = last;
    pending_beats = {pending_beats, b};
  endfunction

  function automatic void push_pool_node(int idx);
    longint ch;
    ch = $urandom_range(0, 4000);
    push_node(idx, longint'($urandom_range(0, 32000)) - 16000,
              longint'($urandom_range(0, 32000)) - 16000, ch,
              ch + $urandom_range(0, 16000),
              longint'($urandom_range(0, 200000)) - 100000,
              longint'($urandom_range(0, 200000)) - 100000);
  endfunction

  function automatic void push_noise_node();
    push_node($urandom_range(0, 1023), $signed($urandom), $signed($urandom),
              $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF),
              $signed($urandom), $signed($urandom));
  endfunction

  function automatic void push_traffic(int count);
    int n, r, k, len, up, dn;
    longint x, y;
    n = 0;
    while (n < count) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        push_pool_node($urandom_range(0, PoolSize - 1));
        n++;
      end else if (r < 14) begin
        push_noise_node();
        n++;
      end else begin
        len = $urandom_range(1, 4);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 99) < 85) begin
            up = $urandom_range(0, PoolSize - 1);
            dn = $urandom_range(0, PoolSize - 1);
          end else begin
            up = $urandom_range(0, 1023);
            dn = $urandom_range(0, 1023);
          end
          if ($urandom_range(0, 99) < 80) begin
            x = longint'($urandom_range(0, 40000)) - 20000;
            y = longint'($urandom_range(0, 40000)) - 20000;
          end else begin
            x = $signed($urandom);
            y = $signed($urandom);
          end
          if ($urandom_range(0, 99) < 5) begin
            push_pool_node($urandom_range(0, PoolSize - 1));
            n++;
          end
          push_query(up, dn, x, y, k == len - 1);
          n++;
        end
      end
    end
  endfunction

  task automatic write_extent(logic [30:0] v);
    @(posedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.data  <= v;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    extent = v;
  endtask

  task automatic drain();
    while (pending_beats.size() != 0 || in_bus.valid || expected_samples.size() != 0)
      @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  // driver
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        predict_beat('{in_bus.kind, in_bus.node_index, in_bus.downstream_index,
                       in_bus.pos_x, in_bus.pos_y, in_bus.channel_half,
                       in_bus.valley_half, in_bus.bed_elevation,
                       in_bus.source_elevation, in_bus.last});
        beats_in++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_bus.valid <= 1'b0;
        end else if (pending_beats.size() != 0) begin
          beat_t b;
          b = pending_beats.pop_front();
          in_bus.valid            <= 1'b1;
          in_bus.kind             <= b.kind;
          in_bus.node_index       <= b.up_idx;
          in_bus.downstream_index <= b.dn_idx;
          in_bus.pos_x            <= b.px;
          in_bus.pos_y            <= b.py;
          in_bus.channel_half     <= b.ch;
          in_bus.valley_half      <= b.va;
          in_bus.bed_elevation    <= b.bed;
          in_bus.source_elevation <= b.src;
          in_bus.last             <= b.last;
          gap_left <= gap_len();
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // long output hold-off while the driver keeps offering
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && beats_in >= 300) begin
      hold_left <= 2500;
      hold_done <= 1'b1;
    end
  end

  // monitor
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        samples_out++;
        if (out_bus.active) active_seen++;
        if (expected_samples.size() == 0) begin
          errors++;
          $display("%0t: unexpected sample beat, active %0b target %0d", $time,
                   out_bus.active, out_bus.target_elevation);
        end else begin
          sample_t e;
          e = expected_samples.pop_front();
          if (out_bus.active !== e.active) begin
            errors++;
            $display("%0t: active exp %0b got %0b", $time, e.active, out_bus.active);
          end
          if (out_bus.target_elevation !== e.target) begin
            errors++;
            $display("%0t: target_elevation exp %0d got %0d", $time, $signed(e.target),
                     out_bus.target_elevation);
          end
          if (out_bus.center_distance !== e.span) begin
            errors++;
            $display("%0t: center_distance exp %0d got %0d", $time, e.span,
                     out_bus.center_distance);
          end
          if (out_bus.influence !== e.infl) begin
            errors++;
            $display("%0t: influence exp %0d got %0d", $time, e.infl, out_bus.influence);
          end
          if (out_bus.out_channel_half !== e.ch) begin
            errors++;
            $display("%0t: out_channel_half exp %0d got %0d", $time, e.ch,
                     out_bus.out_channel_half);
          end
          if (out_bus.out_valley_half !== e.va) begin
            errors++;
            $display("%0t: out_valley_half exp %0d got %0d", $time, e.va,
                     out_bus.out_valley_half);
          end
        end
      end
      if (stall_left > 0) stall_left <= stall_left - 1;
      else stall_left <= gap_len();
      out_bus.ready <= (stall_left == 0) && (hold_left == 0);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d samples outstanding", cycles,
               expected_samples.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    int i;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.kind = rcps_pkg::KindNode;
    in_bus.node_index = '0;
    in_bus.downstream_index = '0;
    in_bus.pos_x = '0;
    in_bus.pos_y = '0;
    in_bus.channel_half = '0;
    in_bus.valley_half = '0;
    in_bus.bed_elevation = '0;
    in_bus.source_elevation = '0;
    in_bus.last = 1'b0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.data = '0;
    extent = 31'h7FFF_FFFF;
    for (i = 0; i < PoolSize * 32; i++) node_loaded[i] = 0;
    clear_best();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    write_extent(31'h7FFF_FFFF);
    // directed: edges of the table, geometry corners and run handling
    push_node(0, 0, 0, 256, 2560, -1000, 5000);
    push_node(1, 25600, 0, 512, 5120, -2000, 4000);
    push_node(2, 0, 0, 300, 3000, 0, 0);
    push_node(3, -64'sd2147483648, 2147483647, 24'hFFFFFF, 24'hFFFFFF,
              -64'sd2147483648, 2147483647);
    push_node(1023, 2147483647, -64'sd2147483648, 0, 0, 2147483647,
              -64'sd2147483648);
    push_query(0, 1, 12800, 300, 1);
    push_query(0, 1, -5000, 0, 0);
    push_query(0, 1, 30000, 100, 1);
    push_query(0, 2, 100, 100, 1);
    push_query(0, 500, 100, 100, 1);
    push_query(0, 1, 12800, 100000, 1);
    push_query(0, 1, 6400, 1000, 0);
    push_query(0, 1, 6400, 1000, 1);
    push_query(0, 1, 6400, 2000, 0);
    push_node(5, 100, 200, 10, 20, 30, 40);
    push_query(1, 5, 6400, 200, 1);
    push_query(3, 1023, 0, 0, 1);
    push_query(3, 1023, -64'sd2147483648, 2147483647, 0);
    push_query(1023, 3, 2147483647, -64'sd2147483648, 1);
    push_query(0, 1, 0, 0, 1);
    for (i = 0; i < PoolSize; i++) push_pool_node(i);
    push_traffic(260);
    drain();

    write_extent(31'd0);
    push_query(0, 1, 0, 0, 1);
    push_query(0, 1, 1, 0, 1);
    push_traffic(230);
    drain();

    calm = 1;
    write_extent(31'd9000);
    push_traffic(240);
    drain();

    calm = 0;
    write_extent(31'($urandom_range(0, 31'h7FFF_FFFF)));
    push_traffic(230);
    drain();

    write_extent(31'h7FFF_FFFF);
    push_traffic(230);
    drain();

    $display("accepted %0d beats over five extent settings, checked %0d samples",
             beats_in, samples_out);
    $display("%0d samples active, long output hold-off %s", active_seen,
             hold_done ? "applied" : "not reached");
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
